[hdl/p2p_pkg.sv]
// ----------------------------------------------------------------------------
// p2p_pkg
// Shared types and constants for the point to pixel sum/count binning block.
// ----------------------------------------------------------------------------
package p2p_pkg;

  // center tables are always 64 deep (6 bit load index)
  localparam int CENTER_DEPTH = 64;
  localparam int CENTER_AW    = 6;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int COORD_W = 24;
  localparam int HALF_W  = 23;
  localparam int VALUE_W = 32;
  localparam int SUM_W   = 48;
  localparam int COUNT_W = 16;
  localparam int USE_W   = 7;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 23;
  localparam int PIX_W   = SUM_W + COUNT_W;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_HALF_X = 2'd0;
  localparam logic [CFG_AW-1:0] REG_HALF_Y = 2'd1;
  localparam logic [CFG_AW-1:0] REG_ROWS   = 2'd2;
  localparam logic [CFG_AW-1:0] REG_COLS   = 2'd3;

  localparam logic [HALF_W-1:0] HALF_RST = 23'd2048;
  localparam logic [USE_W-1:0]  USE_RST  = 7'd64;

  typedef enum logic [2:0] {
    MODE_LOAD_COL = 3'd0,
    MODE_LOAD_ROW = 3'd1,
    MODE_CLEAR    = 3'd2,
    MODE_POINT    = 3'd3,
    MODE_READ     = 3'd4
  } p2p_mode_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ROW_RD,
    S_ROW_CMP,
    S_COL_RD,
    S_COL_CMP,
    S_PIX_RD,
    S_PIX_UPD,
    S_RD_MEM,
    S_RD_OUT
  } p2p_state_t;

endpackage

[hdl/point_to_pixel_sum_count_top.sv]
// ----------------------------------------------------------------------------
// point_to_pixel_sum_count_top
// Bins 2D sample points into a MAX_ROWS x MAX_COLS image of saturating
// sums and counts.
// ----------------------------------------------------------------------------
// Usage: column and row centers (Q12.12) are loaded first with modes 0
// and 1. A point item (mode 3) walks the row centers in turn through a
// single shared subtract/abs/compare unit; for every row whose box holds
// the point it walks the column centers the same way, and each matching
// pixel costs a read-modify-write. The rows and columns walked are those
// in use, capped at the smaller of the image size and 64. A read item
// (mode 4) waits for the output register to drain. A clear item (mode 2),
// and reset itself, run a clearing pass over the pixel memory with
// in_ready low. Configuration writes are taken at any time but must only be
// issued while the block is idle. in_ready is high only in the idle state;
// a finished read result sits in the output register and does not hold off
// the next input transfer.
// ----------------------------------------------------------------------------
module point_to_pixel_sum_count_top #(
  parameter int MAX_ROWS = p2p_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = p2p_pkg::DEF_MAX_COLS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [p2p_pkg::CFG_AW-1:0]          cfg_index,
  input  logic [p2p_pkg::CFG_DW-1:0]          cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_mode,
  input  logic [5:0]                          in_row_index,
  input  logic [5:0]                          in_col_index,
  input  logic signed [p2p_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [p2p_pkg::COORD_W-1:0]  in_coord_y,
  input  logic signed [p2p_pkg::VALUE_W-1:0]  in_point_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [p2p_pkg::SUM_W-1:0]    out_pixel_sum,
  output logic [p2p_pkg::COUNT_W-1:0]         out_pixel_count
);

  import p2p_pkg::*;

  localparam int PIX_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int PIX_AW    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
  // rows/columns a point may walk: bounded by image size and table depth
  localparam int ROW_LIM   = (MAX_ROWS < CENTER_DEPTH) ? MAX_ROWS : CENTER_DEPTH;
  localparam int COL_LIM   = (MAX_COLS < CENTER_DEPTH) ? MAX_COLS : CENTER_DEPTH;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [HALF_W-1:0] half_x_r, half_y_r;
  logic [USE_W-1:0]  rows_use_r, cols_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_x_r   <= HALF_RST;
      half_y_r   <= HALF_RST;
      rows_use_r <= USE_RST;
      cols_use_r <= USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_X: half_x_r   <= cfg_data;
        REG_HALF_Y: half_y_r   <= cfg_data;
        REG_ROWS:   rows_use_r <= cfg_data[USE_W-1:0];
        REG_COLS:   cols_use_r <= cfg_data[USE_W-1:0];
        default:    ;
      endcase
    end
  end

  logic [USE_W-1:0] n_rows, n_cols;
  assign n_rows = (rows_use_r > USE_W'(ROW_LIM)) ? USE_W'(ROW_LIM) : rows_use_r;
  assign n_cols = (cols_use_r > USE_W'(COL_LIM)) ? USE_W'(COL_LIM) : cols_use_r;

  // --------------------------------------------------------------------------
  // sequencer registers
  // --------------------------------------------------------------------------
  p2p_state_t                state_r, state_nxt;
  logic [USE_W-1:0]          r_cnt_r, r_cnt_nxt;
  logic [USE_W-1:0]          c_cnt_r, c_cnt_nxt;
  logic [PIX_AW-1:0]         row_base_r, row_base_nxt;
  logic [PIX_AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic [PIX_AW-1:0]         rd_addr_r, rd_addr_nxt;
  logic                      rd_oob_r, rd_oob_nxt;
  logic signed [COORD_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0]   out_sum_r, out_sum_nxt;
  logic [COUNT_W-1:0]        out_cnt_r, out_cnt_nxt;

  // --------------------------------------------------------------------------
  // memories
  // --------------------------------------------------------------------------
  logic                      col_we, row_we;
  logic [COORD_W-1:0]        col_rdata, row_rdata;
  logic                      pix_we;
  logic [PIX_AW-1:0]         pix_waddr, pix_raddr, pix_addr;
  logic [PIX_W-1:0]          pix_wdata, pix_rdata;

  p2p_ram #(.WIDTH(COORD_W), .DEPTH(CENTER_DEPTH), .AW(CENTER_AW)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (in_col_index),
    .wdata (in_coord_x),
    .raddr (c_cnt_r[CENTER_AW-1:0]),
    .rdata (col_rdata)
  );

  p2p_ram #(.WIDTH(COORD_W), .DEPTH(CENTER_DEPTH), .AW(CENTER_AW)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (in_row_index),
    .wdata (in_coord_x),
    .raddr (r_cnt_r[CENTER_AW-1:0]),
    .rdata (row_rdata)
  );

  // pixel word: count in the upper bits, sum in the lower bits
  p2p_ram #(.WIDTH(PIX_W), .DEPTH(PIX_DEPTH), .AW(PIX_AW)) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pix_wdata),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  // --------------------------------------------------------------------------
  // shared distance unit: |a - center| < half
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] cmp_a, cmp_b;
  logic [HALF_W-1:0]         cmp_half;
  logic signed [COORD_W:0]   cmp_diff;
  logic [COORD_W:0]          cmp_abs;
  logic                      cmp_hit;

  always_comb begin
    if (state_r == S_ROW_CMP) begin
      cmp_a    = py_r;
      cmp_b    = row_rdata;
      cmp_half = half_y_r;
    end else begin
      cmp_a    = px_r;
      cmp_b    = col_rdata;
      cmp_half = half_x_r;
    end
    cmp_diff = {cmp_a[COORD_W-1], cmp_a} - {cmp_b[COORD_W-1], cmp_b};
    cmp_abs  = cmp_diff[COORD_W] ? (COORD_W+1)'(-cmp_diff) : cmp_diff;
    cmp_hit  = cmp_abs < {2'b00, cmp_half};
  end

  // --------------------------------------------------------------------------
  // saturating pixel update
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] old_sum, new_sum;
  logic [COUNT_W-1:0]      old_cnt, new_cnt;
  logic signed [SUM_W:0]   sum_ext;

  always_comb begin
    old_sum = pix_rdata[SUM_W-1:0];
    old_cnt = pix_rdata[PIX_W-1:SUM_W];
    sum_ext = {old_sum[SUM_W-1], old_sum} + (SUM_W+1)'(val_r);
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      new_sum = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      new_sum = sum_ext[SUM_W-1:0];
    end
    new_cnt = (&old_cnt) ? old_cnt : old_cnt + 1'b1;
  end

  assign pix_addr = row_base_r + PIX_AW'(c_cnt_r);

  // --------------------------------------------------------------------------
  // state register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      r_cnt_r     <= '0;
      c_cnt_r     <= '0;
      row_base_r  <= '0;
      clr_addr_r  <= '0;
      rd_oob_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      r_cnt_r     <= r_cnt_nxt;
      c_cnt_r     <= c_cnt_nxt;
      row_base_r  <= row_base_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_oob_r    <= rd_oob_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    val_r     <= val_nxt;
    rd_addr_r <= rd_addr_nxt;
    out_sum_r <= out_sum_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  // --------------------------------------------------------------------------
  // sequencer: next state and memory controls
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    r_cnt_nxt     = r_cnt_r;
    c_cnt_nxt     = c_cnt_r;
    row_base_nxt  = row_base_r;
    clr_addr_nxt  = clr_addr_r;
    rd_addr_nxt   = rd_addr_r;
    rd_oob_nxt    = rd_oob_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r;
    out_sum_nxt   = out_sum_r;
    out_cnt_nxt   = out_cnt_r;

    in_ready  = 1'b0;
    col_we    = 1'b0;
    row_we    = 1'b0;
    pix_we    = 1'b0;
    pix_waddr = pix_addr;
    pix_wdata = {new_cnt, new_sum};
    pix_raddr = pix_addr;

    // result leaves the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        pix_we    = 1'b1;
        pix_waddr = clr_addr_r;
        pix_wdata = '0;
        if (clr_addr_r == PIX_AW'(PIX_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
        clr_addr_nxt = clr_addr_r + 1'b1;
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_mode)
            MODE_LOAD_COL: col_we = (32'(in_col_index) < MAX_COLS);
            MODE_LOAD_ROW: row_we = (32'(in_row_index) < MAX_ROWS);
            MODE_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = S_CLEAR;
            end
            MODE_POINT: begin
              px_nxt       = in_coord_x;
              py_nxt       = in_coord_y;
              val_nxt      = in_point_value;
              r_cnt_nxt    = '0;
              c_cnt_nxt    = '0;
              row_base_nxt = '0;
              if (n_rows != '0) begin
                state_nxt = S_ROW_RD;
              end
            end
            MODE_READ: begin
              rd_oob_nxt  = !((32'(in_row_index) < MAX_ROWS) &&
                              (32'(in_col_index) < MAX_COLS));
              rd_addr_nxt = PIX_AW'(32'(in_row_index) * MAX_COLS + 32'(in_col_index));
              state_nxt   = S_RD_MEM;
            end
            default: ;
          endcase
        end
      end

      // row center read is in flight
      S_ROW_RD: state_nxt = S_ROW_CMP;

      S_ROW_CMP: begin
        if (cmp_hit && (n_cols != '0)) begin
          c_cnt_nxt = '0;
          state_nxt = S_COL_RD;
        end else begin
          r_cnt_nxt    = r_cnt_r + 1'b1;
          row_base_nxt = row_base_r + PIX_AW'(MAX_COLS);
          state_nxt    = (r_cnt_r + 1'b1 < n_rows) ? S_ROW_RD : S_IDLE;
        end
      end

      S_COL_RD: state_nxt = S_COL_CMP;

      S_COL_CMP: begin
        if (cmp_hit) begin
          state_nxt = S_PIX_RD;
        end else if (c_cnt_r + 1'b1 < n_cols) begin
          c_cnt_nxt = c_cnt_r + 1'b1;
          state_nxt = S_COL_RD;
        end else begin
          r_cnt_nxt    = r_cnt_r + 1'b1;
          row_base_nxt = row_base_r + PIX_AW'(MAX_COLS);
          state_nxt    = (r_cnt_r + 1'b1 < n_rows) ? S_ROW_RD : S_IDLE;
        end
      end

      // pixel word read in flight
      S_PIX_RD: state_nxt = S_PIX_UPD;

      S_PIX_UPD: begin
        pix_we = 1'b1;
        if (c_cnt_r + 1'b1 < n_cols) begin
          c_cnt_nxt = c_cnt_r + 1'b1;
          state_nxt = S_COL_RD;
        end else begin
          r_cnt_nxt    = r_cnt_r + 1'b1;
          row_base_nxt = row_base_r + PIX_AW'(MAX_COLS);
          state_nxt    = (r_cnt_r + 1'b1 < n_rows) ? S_ROW_RD : S_IDLE;
        end
      end

      S_RD_MEM: begin
        pix_raddr = rd_addr_r;
        state_nxt = S_RD_OUT;
      end

      // read address held so the RAM output stays put while we wait
      S_RD_OUT: begin
        pix_raddr = rd_addr_r;
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = rd_oob_r ? '0 : pix_rdata[SUM_W-1:0];
          out_cnt_nxt   = rd_oob_r ? '0 : pix_rdata[PIX_W-1:SUM_W];
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_sum   = out_sum_r;
  assign out_pixel_count = out_cnt_r;

endmodule

[hdl/p2p_ram.sv]
// ----------------------------------------------------------------------------
// p2p_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module p2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
